// File: rtl/core/pixel_dim_and_contrast_assert.svh
// Assertion macros shared by the pixel dimming and contrast block.
`ifndef PIXEL_DIM_AND_CONTRAST_ASSERT_SVH
`define PIXEL_DIM_AND_CONTRAST_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PDC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pdc check failed: name");
`define PDC_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("pdc check failed: name");
`else
`define PDC_ASSERT(name, clk, rst_n, prop)
`define PDC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: rtl/core/pdc_pkg.sv
`timescale 1ns / 1ps

package pdc_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned FULL_SCALE = 255;
	localparam int unsigned GAIN_ZERO = 128;
	localparam int unsigned MID_GREY = 127;
	localparam int unsigned DIM_DIVISOR = 3;

	// floor(s / 3) == (s * THIRD_MUL) >> THIRD_SHIFT for every s below 512.
	localparam int unsigned THIRD_SHIFT = 9;
	localparam int unsigned THIRD_MUL = (1 << THIRD_SHIFT) / DIM_DIVISOR + 1;

	// Smallest non-negative sum whose quotient by full scale exceeds full scale.
	localparam int unsigned SAT_LIMIT = FULL_SCALE * (FULL_SCALE + 1);

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

// File: rtl/core/pdc_ctrl.sv
`timescale 1ns / 1ps
`include "pixel_dim_and_contrast_assert.svh"

module pdc_ctrl import pdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output pipe_en_t en
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	always_comb begin
		en.s3 = !valid_s3 || !out_stall;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= in_valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// An accepted beat always lands in the first stage.
	`PDC_ASSERT(a_accept_lands, clk, arst_n, in_valid && !in_stall |=> valid_s1)
	// A held stage keeps its beat rather than dropping it.
	`PDC_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !en.s2 |=> valid_s1)
	`PDC_ASSERT(a_s2_holds, clk, arst_n, valid_s2 && !en.s3 |=> valid_s2)
	// The last stage never moves while a waiting beat is stalled.
	`PDC_ASSERT_ALWAYS(a_s3_no_overwrite, clk, !(en.s3 && valid_s3 && out_stall))

endmodule

// File: rtl/core/pdc_lane.sv
`timescale 1ns / 1ps

module pdc_lane import pdc_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [CHAN_W-1:0] chan_in,
	input  logic [CHAN_W-1:0] strength,
	output logic [CHAN_W-1:0] chan_out
);

	localparam int unsigned NUM_W = 2 * CHAN_W + 2;

	logic [15:0]             third_prod;
	logic [6:0]              third;
	logic [CHAN_W:0]         dimmed;
	logic [CHAN_W-1:0]       c1_s1;
	logic signed [CHAN_W-1:0] k_s1;

	logic signed [CHAN_W:0]   dev;
	logic signed [2*CHAN_W:0] gain_term;
	logic [2*CHAN_W-1:0]      scaled;
	logic signed [NUM_W-1:0]  num_s2;

	logic [2*CHAN_W-1:0] x16;
	logic [CHAN_W-1:0]   est;
	logic [2*CHAN_W-1:0] est_back;
	logic [2*CHAN_W-1:0] rem;
	logic [CHAN_W-1:0]   quot;
	logic [CHAN_W-1:0]   q_s3;

	// Stage 1: dim by a third of the strength, clamp at black.
	always_comb begin
		third_prod = 16'(strength) * 16'(THIRD_MUL);
		third      = third_prod[15:THIRD_SHIFT];
		dimmed     = {1'b0, chan_in} - {2'b00, third};
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			c1_s1 <= dimmed[CHAN_W] ? '0 : dimmed[CHAN_W-1:0];
			k_s1  <= $signed(strength - CHAN_W'(GAIN_ZERO));
		end
	end

	// Stage 2: contrast sum 255*c1 + k*(c1 - 127).
	always_comb begin
		dev       = $signed({1'b0, c1_s1}) - $signed((CHAN_W + 1)'(MID_GREY));
		gain_term = (2 * CHAN_W + 1)'(k_s1 * dev);
		scaled    = {c1_s1, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c1_s1};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2 <= $signed({2'b00, scaled}) + $signed({gain_term[2*CHAN_W], gain_term});
		end
	end

	// Stage 3: floor division by full scale with one correction, then saturation.
	always_comb begin
		x16      = num_s2[2*CHAN_W-1:0];
		est      = x16[2*CHAN_W-1:CHAN_W];
		est_back = {est, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, est};
		rem      = x16 - est_back;
		quot     = (rem >= (2*CHAN_W)'(FULL_SCALE)) ? est + 1'b1 : est;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (num_s2[NUM_W-1]) begin
				q_s3 <= '0;
			end else if (num_s2 >= $signed(NUM_W'(SAT_LIMIT))) begin
				q_s3 <= CHAN_W'(FULL_SCALE);
			end else begin
				q_s3 <= quot;
			end
		end
	end

	assign chan_out = q_s3;

endmodule

// File: rtl/core/pixel_dim_and_contrast.sv
`timescale 1ns / 1ps

// Dims each channel of a BGR pixel by a third of the row strength and then applies a
// contrast stretch about mid-grey with gain (strength - 128) / 255, saturating to 0..255.
// The block takes one pixel per clock while in_stall is low, and passes each accepted input beat
// through three registered pipeline stages; each stage stalls on its own, so a stalled output
// holds only the stages behind it that are full and bubbles are absorbed.
module pixel_dim_and_contrast import pdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] blue_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] row_strength,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAN_W-1:0] blue_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] red_out
);

	pipe_en_t en;

	pdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	pdc_lane u_blue (
		.clk      (clk),
		.en       (en),
		.chan_in  (blue_in),
		.strength (row_strength),
		.chan_out (blue_out)
	);

	pdc_lane u_green (
		.clk      (clk),
		.en       (en),
		.chan_in  (green_in),
		.strength (row_strength),
		.chan_out (green_out)
	);

	pdc_lane u_red (
		.clk      (clk),
		.en       (en),
		.chan_in  (red_in),
		.strength (row_strength),
		.chan_out (red_out)
	);

endmodule

// File: bench/pixel_dim_and_contrast_checker.sv
`timescale 1ns / 1ps

module pixel_dim_and_contrast_checker import pdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CHAN_W-1:0] blue_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] row_strength,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [CHAN_W-1:0] blue_out,
	input  logic [CHAN_W-1:0] green_out,
	input  logic [CHAN_W-1:0] red_out,
	output int                fails,
	output int                pending
);

	localparam int FullScale = 255;
	localparam int GainZero = 128;
	localparam int MidGrey = 127;
	localparam int DimDivisor = 3;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	pixel_t adjusted_q[$];
	pixel_t want_px;

	// Dimming by a third of the strength, then a stretch about mid-grey, floored and saturated.
	function automatic logic [CHAN_W-1:0] dim_and_stretch(input logic [CHAN_W-1:0] level,
			input logic [CHAN_W-1:0] strength);
		int dimmed;
		int num;
		int quot;
		dimmed = int'(level) - int'(strength) / DimDivisor;
		if (dimmed < 0)
			dimmed = 0;
		num = FullScale * dimmed + (int'(strength) - GainZero) * (dimmed - MidGrey);
		if (num < 0)
			return '0;
		quot = num / FullScale;
		if (quot > FullScale)
			quot = FullScale;
		return quot[CHAN_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	task automatic check_channel(input string name, input logic [CHAN_W-1:0] got,
			input logic [CHAN_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (adjusted_q.size() == 0) begin
					report_mismatch($sformatf("output beat with nothing expected: %0d %0d %0d",
						blue_out, green_out, red_out));
				end else begin
					want_px = adjusted_q.pop_front();
					check_channel("blue_out", blue_out, want_px.blue);
					check_channel("green_out", green_out, want_px.green);
					check_channel("red_out", red_out, want_px.red);
				end
			end
			if (in_valid && !in_stall) begin
				adjusted_q.push_back({dim_and_stretch(blue_in, row_strength),
					dim_and_stretch(green_in, row_strength),
					dim_and_stretch(red_in, row_strength)});
			end
			pending <= adjusted_q.size();
		end
	end

endmodule

// File: bench/pixel_dim_and_contrast_tb.sv
`timescale 1ns / 1ps

module pixel_dim_and_contrast_tb;
	import pdc_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int LongHold = 200;
	localparam int PhaseItems = 100;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CHAN_W-1:0] blue_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] row_strength;
	logic              out_valid;
	logic              out_stall;
	logic [CHAN_W-1:0] blue_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] red_out;
	int                fails;
	int                pending;

	int   sender_idle_max = 3;
	int   receiver_idle_max = 3;
	logic long_hold_req = 1'b0;
	int   cycles = 0;

	logic [CHAN_W-1:0] edge_strengths [9] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd129,
		8'd254, 8'd255};

	pixel_dim_and_contrast u_dut (.*);

	pixel_dim_and_contrast_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return CHAN_W'($urandom_range(120, 135));
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] s);
		int gap;
		gap = $urandom_range(0, sender_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue_in <= b;
		green_in <= g;
		red_in <= r;
		row_strength <= s;
		do @(posedge clk); while (in_stall);
	endtask

	// The receiver takes its own idle draws; on request it holds off for a long stretch.
	initial begin
		int wait_cycles;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				wait_cycles = $urandom_range(0, receiver_idle_max);
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("** pixel_dim_and_contrast: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		blue_in = '0;
		green_in = '0;
		red_in = '0;
		row_strength = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (edge_strengths[i]) begin
			send_pixel(8'd255, 8'd0, 8'd127, edge_strengths[i]);
			send_pixel(8'd128, 8'd1, 8'd254, edge_strengths[i]);
		end
		// Dimming below black, a negative stretch, the brightest corner and mid-grey at unit gain.
		send_pixel(8'd10, 8'd5, 8'd0, 8'd90);
		send_pixel(8'd50, 8'd0, 8'd100, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'd127, 8'd127, 8'd127, 8'd128);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_max = 11;
					receiver_idle_max = 11;
				end
				1: begin
					sender_idle_max = 0;
					receiver_idle_max = 0;
					long_hold_req = 1'b1;
				end
				2: begin
					sender_idle_max = 0;
					receiver_idle_max = 11;
				end
				default: begin
					sender_idle_max = 11;
					receiver_idle_max = 0;
				end
			endcase
			repeat (PhaseItems)
				send_pixel(pick_level(), pick_level(), pick_level(), pick_level());
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("** pixel_dim_and_contrast: PASSED **");
		else
			$display("** pixel_dim_and_contrast: FAILED **");
		$finish;
	end

endmodule
